### design/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef logic [31:0] word_t;
    typedef word_t [7:0] hash_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        unique case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

### design/sha256_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire sha256_pkg::in_item_t push_data,
    output logic                      full,
    input  wire logic                 pop,
    output sha256_pkg::in_item_t      pop_data,
    output logic                      empty
);

    sha256_pkg::in_item_t mem [sha256_pkg::QUEUE_DEPTH];
    logic [sha256_pkg::QUEUE_AW:0] wr_reg, rd_reg;

    assign empty = (wr_reg == rd_reg);
    assign full = (wr_reg[sha256_pkg::QUEUE_AW] != rd_reg[sha256_pkg::QUEUE_AW])
        && (wr_reg[sha256_pkg::QUEUE_AW-1:0] == rd_reg[sha256_pkg::QUEUE_AW-1:0]);
    assign pop_data = mem[rd_reg[sha256_pkg::QUEUE_AW-1:0]];

    always_ff @(posedge clk) begin
        if (push && !full)
        begin
            mem[wr_reg[sha256_pkg::QUEUE_AW-1:0]] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/sha256_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire sha256_pkg::in_item_t item,
    output logic                      item_take,
    output logic                      out_valid,
    output sha256_pkg::out_item_t     out_data,
    input  wire logic                 out_ready
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT
    } state_t;

    state_t                state_reg;
    sha256_pkg::hash_t     hash_reg;
    sha256_pkg::hash_t     v_reg;
    sha256_pkg::word_t     w_reg [16];
    logic [5:0]            fill_reg;
    logic [63:0]           bits_reg;
    logic [5:0]            t_reg;
    logic [2:0]            idx_reg;
    logic                  final_reg;
    logic                  second_reg;
    logic                  out_valid_reg;
    sha256_pkg::out_item_t out_reg;

    sha256_pkg::word_t s0, s1, w_new, t1, t2, w_cur, e, a, pad_word;
    logic [7:0] pad_byte;
    logic [1:0] bsel;

    assign item_take = (state_reg == S_IDLE) && item_valid;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // w_reg holds message words; word k of block in w_reg[k] during load
    assign bsel = fill_reg[1:0];
    assign s0 = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
        ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign w_cur = w_reg[0];
    assign e = v_reg[4];
    assign a = v_reg[0];
    assign t1 = v_reg[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
        ^ sha256_pkg::rotr(e, 25)) + ((e & v_reg[5]) ^ (~e & v_reg[6]))
        + sha256_pkg::round_k(t_reg) + w_cur;
    assign t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
        + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // pad byte placement during S_PAD: walks one byte a cycle from fill_reg
    always_comb begin
        pad_byte = 8'h00;
        if (!second_reg && fill_reg == t_reg)
        begin
            pad_byte = 8'h80;
        end
        pad_word = w_reg[fill_reg[5:2]];
        unique case (bsel)
            2'd0: pad_word[31:24] = pad_byte;
            2'd1: pad_word[23:16] = pad_byte;
            2'd2: pad_word[15:8] = pad_byte;
            2'd3: pad_word[7:0] = pad_byte;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hash_reg <= sha256_pkg::INIT_HASH;
            v_reg <= '0;
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
            fill_reg <= '0;
            bits_reg <= '0;
            t_reg <= '0;
            idx_reg <= '0;
            final_reg <= 1'b0;
            second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (item.action == sha256_pkg::ACT_ABSORB)
                        begin
                            unique case (bsel)
                                2'd0: w_reg[fill_reg[5:2]][31:24] <= item.data_byte;
                                2'd1: w_reg[fill_reg[5:2]][23:16] <= item.data_byte;
                                2'd2: w_reg[fill_reg[5:2]][15:8] <= item.data_byte;
                                2'd3: w_reg[fill_reg[5:2]][7:0] <= item.data_byte;
                                default: ;
                            endcase
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= fill_reg + 6'd1;
                            if (fill_reg == 6'd63)
                            begin
                                final_reg <= 1'b0;
                                second_reg <= 1'b0;
                                t_reg <= '0;
                                v_reg <= hash_reg;
                                state_reg <= S_ROUND;
                            end
                        end
                        else
                        begin
                            // t_reg marks where 0x80 goes
                            t_reg <= fill_reg;
                            second_reg <= 1'b0;
                            final_reg <= 1'b1;
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    if (!second_reg && fill_reg == 6'd56 && t_reg < 6'd56)
                    begin
                        w_reg[14] <= bits_reg[63:32];
                        w_reg[15] <= bits_reg[31:0];
                        fill_reg <= '0;
                        v_reg <= hash_reg;
                        t_reg <= '0;
                        final_reg <= 1'b1;
                        state_reg <= S_ROUND;
                    end
                    else if (second_reg && fill_reg == 6'd56)
                    begin
                        w_reg[14] <= bits_reg[63:32];
                        w_reg[15] <= bits_reg[31:0];
                        fill_reg <= '0;
                        v_reg <= hash_reg;
                        t_reg <= '0;
                        final_reg <= 1'b1;
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        w_reg[fill_reg[5:2]] <= pad_word;
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            // overflow block: compress, then second pad block
                            v_reg <= hash_reg;
                            t_reg <= '0;
                            final_reg <= 1'b0;
                            second_reg <= 1'b1;
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    t_reg <= t_reg + 6'd1;
                    if (t_reg == 6'd63)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    t_reg <= '0;
                    if (final_reg)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (second_reg)
                    begin
                        // after the overflow block compresses, fall into the length block
                        state_reg <= S_PAD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.digest_word <= hash_reg[idx_reg];
                        out_reg.word_index <= idx_reg;
                        out_reg.last_word <= (idx_reg == 3'd7);
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            hash_reg <= sha256_pkg::INIT_HASH;
                            fill_reg <= '0;
                            bits_reg <= '0;
                            final_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (out_valid_reg && out_ready && !(state_reg == S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### design/sha256_message_hasher_top.sv
`timescale 1ns / 1ps
`default_nettype none

// absorb: bytes taken only while idle; every 64th byte compresses the block (64 rounds + add)
// finish: pad up to byte 56, add the bit length, compress the last block, then 8 digest words
// fill of 56 or more at finish: pad to 64, one block, then zeros and the length, one more block
// throughput is set by the single shared round unit in the back end
// rst_n asynchronous, active low: hash to initial values, counts to zero, queue empty

module sha256_message_hasher_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sha256_pkg::in_item_t in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sha256_pkg::out_item_t     out_data
);

    logic full, empty, take;
    sha256_pkg::in_item_t q_data;

    assign in_ready = !full;

    sha256_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_valid), .push_data(in_data), .full(full),
        .pop(take), .pop_data(q_data), .empty(empty)
    );

    sha256_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .item_valid(!empty), .item(q_data), .item_take(take),
        .out_valid(out_valid), .out_data(out_data), .out_ready(out_ready)
    );

endmodule

`default_nettype wire

### design/sha256_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire sha256_pkg::out_item_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
        else $error("last flag mismatch");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word ##1 out_valid |->
        out_data.word_index == $past(out_data.word_index) + 3'd1)
        else $error("word order broken");

endmodule

bind sha256_message_hasher_top sha256_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
);

`default_nettype wire
